// ===== hdl/ffsd_pkg.sv =====
// shared types and constants for the fixed frame sync deframer
// no dependencies; imported by the window, emit and top level modules
package ffsd_pkg;

    // field widths fixed by the interface
    localparam int BYTE_W        = 8;
    localparam int BYTE_POS_W    = 6;
    localparam int FRAME_LEN_W   = 7;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    // default depth of the frame window
    localparam int MAX_FRAME_LEN_DEF = 64;

    // reset values of the configuration registers
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 7'd16;
    localparam logic [BYTE_W-1:0]      HEADER_RST    = 8'd0;
    localparam logic [BYTE_W-1:0]      TRAILER_RST   = 8'd0;

    // shortest legal frame: two header bytes and a trailer
    localparam logic [FRAME_LEN_W-1:0] MIN_FRAME_LEN = 7'd3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_LENGTH  = 2'd0,
        REG_HEADER_FIRST  = 2'd1,
        REG_HEADER_SECOND = 2'd2,
        REG_TRAILER_VALUE = 2'd3
    } ffsd_reg_t;

    // configuration as seen by the window logic
    typedef struct packed {
        logic [FRAME_LEN_W-1:0] frame_length;
        logic [BYTE_W-1:0]      header_first;
        logic [BYTE_W-1:0]      header_second;
        logic [BYTE_W-1:0]      trailer_value;
    } ffsd_cfg_t;

    // frame hand-off from window to emitter
    typedef struct packed {
        logic                  load;
        logic [BYTE_POS_W-1:0] last_pos;
    } ffsd_load_t;

endpackage

// ===== hdl/ffsd_window.sv =====
// sliding receive window: append, slide, trim and frame match detection
// depends on ffsd_pkg
module ffsd_window
    import ffsd_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ffsd_cfg_t         cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              emit_free,
    output ffsd_load_t        load,
    output logic [BYTE_W-1:0] frame [MAX_FRAME_LEN]
);

    localparam int FILL_W = $clog2(MAX_FRAME_LEN);

    logic [BYTE_W-1:0] win_reg [MAX_FRAME_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] len_m1;
    logic              trim;
    logic              full;
    logic              hit;
    logic              accept;
    logic              slide;

    // effective frame length minus one, clamped to the legal range
    always_comb
    begin
        if (cfg.frame_length < MIN_FRAME_LEN)
        begin
            len_m1 = FILL_W'(MIN_FRAME_LEN - 7'd1);
        end
        else if (cfg.frame_length > FRAME_LEN_W'(MAX_FRAME_LEN))
        begin
            len_m1 = FILL_W'(MAX_FRAME_LEN - 1);
        end
        else
        begin
            len_m1 = FILL_W'(cfg.frame_length - 7'd1);
        end
    end

    // window status and match on the incoming trailer byte
    assign trim     = fill_reg > len_m1;
    assign full     = fill_reg == len_m1;
    assign hit      = full && (win_reg[0] == cfg.header_first)
                      && (win_reg[1] == cfg.header_second)
                      && (rx_byte == cfg.trailer_value);
    assign in_ready = !trim && (!full || emit_free);
    assign accept   = in_valid && in_ready;
    assign slide    = trim || (accept && full && !hit);

    assign load.load     = accept && hit;
    assign load.last_pos = BYTE_POS_W'(len_m1);

    // fill count
    always_comb
    begin
        if (trim)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
        else if (accept && hit)
        begin
            fill_next = '0;
        end
        else if (accept && !full)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // window entries: slide toward the oldest slot, new byte at the fill point
    for (genvar k = 0; k < MAX_FRAME_LEN; k++)
    begin : g_win
        logic [BYTE_W-1:0] shift_src;

        if (k == MAX_FRAME_LEN - 1)
        begin : g_tail
            assign shift_src = win_reg[k];
        end
        else
        begin : g_body
            assign shift_src = win_reg[k+1];
        end

        // frame as it stands with the new byte in place
        assign frame[k] = (FILL_W'(k) == fill_reg) ? rx_byte : win_reg[k];

        always_ff @(posedge clk)
        begin
            if (slide)
            begin
                if (accept && (FILL_W'(k) == fill_reg - FILL_W'(1)))
                begin
                    win_reg[k] <= rx_byte;
                end
                else
                begin
                    win_reg[k] <= shift_src;
                end
            end
            else if (accept && !full && (FILL_W'(k) == fill_reg))
            begin
                win_reg[k] <= rx_byte;
            end
        end
    end

endmodule

// ===== hdl/ffsd_emit.sv =====
// frame buffer that drains an accepted frame one output beat per byte
// depends on ffsd_pkg
module ffsd_emit
    import ffsd_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffsd_load_t            load,
    input  logic [BYTE_W-1:0]     frame [MAX_FRAME_LEN],
    output logic                  emit_free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     frame_byte,
    output logic [BYTE_POS_W-1:0] byte_position,
    output logic                  frame_last
);

    localparam int POS_W = $clog2(MAX_FRAME_LEN);

    logic [BYTE_W-1:0] buf_reg [MAX_FRAME_LEN];
    logic              valid_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  last_reg;
    logic              beat;
    logic              done;

    // output beat and end of frame
    assign beat      = valid_reg && out_ready;
    assign done      = beat && (pos_reg == last_reg);
    assign emit_free = !valid_reg || done;

    assign out_valid     = valid_reg;
    assign frame_byte    = buf_reg[0];
    assign byte_position = BYTE_POS_W'(pos_reg);
    assign frame_last    = pos_reg == last_reg;

    // drain control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
            last_reg  <= '0;
        end
        else if (load.load)
        begin
            valid_reg <= 1'b1;
            pos_reg   <= '0;
            last_reg  <= load.last_pos[POS_W-1:0];
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
        end
        else if (beat)
        begin
            pos_reg <= pos_reg + POS_W'(1);
        end
    end

    // buffer: parallel load, then shift one byte per beat
    for (genvar k = 0; k < MAX_FRAME_LEN; k++)
    begin : g_buf
        logic [BYTE_W-1:0] shift_src;

        if (k == MAX_FRAME_LEN - 1)
        begin : g_tail
            assign shift_src = buf_reg[k];
        end
        else
        begin : g_body
            assign shift_src = buf_reg[k+1];
        end

        always_ff @(posedge clk)
        begin
            if (load.load)
            begin
                buf_reg[k] <= frame[k];
            end
            else if (beat)
            begin
                buf_reg[k] <= shift_src;
            end
        end
    end

endmodule

// ===== hdl/fixed_frame_sync_deframer_unit.sv =====
// top level of the fixed frame sync deframer: config registers, window, emitter
// depends on ffsd_pkg, ffsd_window and ffsd_emit
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_ready   rx_byte
//  output    out        out_valid / out_ready frame_byte, byte_position, frame_last
//  config    in         cfg_wr_en             cfg_index, cfg_data
//
// one received byte is taken per cycle while in_ready is high; the match is decided
// in the same cycle from the two oldest window bytes and the incoming byte
// a matched frame of n bytes is copied to the frame buffer and leaves in n output beats;
// input stalls when the window holds n-1 bytes and the previous frame is still draining
// after frame_length is lowered the window drops one byte per cycle, input held off,
// until n-1 bytes remain
// reset empties the window and the frame buffer and loads the register defaults
module fixed_frame_sync_deframer_unit
    import ffsd_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [BYTE_W-1:0]      frame_byte,
    output logic [BYTE_POS_W-1:0]  byte_position,
    output logic                   frame_last,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ffsd_cfg_t         cfg_reg;
    ffsd_load_t        load;
    logic              emit_free;
    logic [BYTE_W-1:0] frame [MAX_FRAME_LEN];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_length  <= FRAME_LEN_RST;
            cfg_reg.header_first  <= HEADER_RST;
            cfg_reg.header_second <= HEADER_RST;
            cfg_reg.trailer_value <= TRAILER_RST;
        end
        else if (cfg_wr_en)
        begin
            case (ffsd_reg_t'(cfg_index))
                REG_FRAME_LENGTH:  cfg_reg.frame_length  <= cfg_data[FRAME_LEN_W-1:0];
                REG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data[BYTE_W-1:0];
                REG_HEADER_SECOND: cfg_reg.header_second <= cfg_data[BYTE_W-1:0];
                REG_TRAILER_VALUE: cfg_reg.trailer_value <= cfg_data[BYTE_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // receive window and match
    ffsd_window #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .emit_free (emit_free),
        .load      (load),
        .frame     (frame)
    );

    // frame output
    ffsd_emit #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .frame         (frame),
        .emit_free     (emit_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .frame_last    (frame_last)
    );

endmodule
